// File: design/base64_stream_decoder_macros.svh
// Assertion macros shared by the base64 stream decoder checker.
// No dependencies; expects signals named clock and reset in scope.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// same-cycle implication, off during reset
`define B64D_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define B64D_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers the reset cycles
`define B64D_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/b64d_pkg.sv
// Shared types and constants of the base64 stream decoder.
// No dependencies.
package b64d_pkg;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_SYMBOL = 2'd1;
   localparam logic [1:0] STATUS_LENGTH = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // one decoded group: up to three bytes, data[0] goes out first
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;   // 1..3 beats
      logic            last;
      logic [1:0]      status;
   } entry_type;

endpackage

// File: design/b64d_front.sv
// Front end: accepts characters, classifies them and tracks group state.
// Depends on b64d_pkg; pushes finished groups into b64d_queue.
module b64d_front import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       alphabet_select,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_symbol,
   input  logic       req_final_symbol,
   input  logic       queue_ready,
   output logic       push,
   output entry_type  push_entry
);

   typedef struct packed {
      logic       valid;
      logic       pad;
      logic [5:0] value;
   } sextet_type;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   function automatic sextet_type classify(input logic [7:0] c, input logic url);
      sextet_type s;
      logic [7:0] d;
      s = '{valid: 1'b1, pad: 1'b0, value: 6'd0};
      d = 8'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         d = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30 + 8'd52;
      end else if (c == PAD_CHAR) begin
         s.pad = 1'b1;
      end else if (!url && c == 8'h2B) begin
         d = 8'd62;
      end else if (!url && c == 8'h2F) begin
         d = 8'd63;
      end else if (url && c == 8'h2D) begin
         d = 8'd62;
      end else if (url && c == 8'h5F) begin
         d = 8'd63;
      end else begin
         s.valid = 1'b0;
      end
      s.value = d[5:0];
      return s;
   endfunction

   logic [1:0]  group_position_ff, group_position_in;
   logic [17:0] held_sextets_ff, held_sextets_in;
   logic [1:0]  pad_count_ff, pad_count_in;
   logic [1:0]  error_code_ff, error_code_in;

   sextet_type  cls;
   logic [17:0] held_eff;
   logic [7:0]  b0, b1, b2;
   logic [2:0][7:0] bytes;
   logic [1:0]  n_bytes;
   logic [1:0]  status;
   logic        push_req;
   logic        accept;

   assign req_ready = queue_ready;
   assign accept    = req_valid & req_ready;
   assign push      = accept & push_req;

   always_comb begin
      cls      = classify(req_symbol, alphabet_select);
      held_eff = (group_position_ff == 2'd0) ? 18'd0 : held_sextets_ff;
      b0 = {held_eff[17:12], held_eff[11:10]};
      b1 = {held_eff[9:6], held_eff[5:2]};
      b2 = {held_eff[1:0], cls.value};

      error_code_in   = error_code_ff;
      held_sextets_in = held_sextets_ff;
      pad_count_in    = pad_count_ff;
      bytes           = '0;
      n_bytes         = 2'd0;

      if (error_code_ff == STATUS_OK) begin
         held_sextets_in = held_eff;
         if (!cls.valid) begin
            error_code_in = STATUS_SYMBOL;
         end else if (cls.pad) begin
            if (group_position_ff < 2'd2 ||
                (group_position_ff == 2'd2 && pad_count_ff != 2'd0)) begin
               error_code_in = STATUS_SYMBOL;
            end else if (group_position_ff == 2'd2) begin
               pad_count_in = 2'd1;
            end else begin
               bytes[0] = b0;
               if (pad_count_ff == 2'd0) begin
                  bytes[1]     = b1;
                  n_bytes      = 2'd2;
                  pad_count_in = 2'd1;
               end else begin
                  n_bytes      = 2'd1;
                  pad_count_in = 2'd2;
               end
            end
         end else if (pad_count_ff != 2'd0) begin
            error_code_in = STATUS_SYMBOL;
         end else begin
            case (group_position_ff)
               2'd0: held_sextets_in[17:12] = cls.value;
               2'd1: held_sextets_in[11:6]  = cls.value;
               2'd2: held_sextets_in[5:0]   = cls.value;
               default: begin
                  bytes   = {b2, b1, b0};
                  n_bytes = 2'd3;
               end
            endcase
         end
      end

      group_position_in = group_position_ff + 2'd1;

      status     = (group_position_in != 2'd0) ? STATUS_LENGTH : error_code_in;
      push_entry = '{data: bytes, count: n_bytes, last: 1'b0, status: STATUS_OK};
      push_req   = (n_bytes != 2'd0);

      if (req_final_symbol) begin
         push_req = 1'b1;
         if (status != STATUS_OK) begin
            push_entry = '{data: '0, count: 2'd1, last: 1'b1, status: status};
         end else begin
            push_entry.last = 1'b1;
         end
         group_position_in = 2'd0;
         held_sextets_in   = 18'd0;
         pad_count_in      = 2'd0;
         error_code_in     = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_position_ff <= 2'd0;
         held_sextets_ff   <= 18'd0;
         pad_count_ff      <= 2'd0;
         error_code_ff     <= STATUS_OK;
      end else if (accept) begin
         group_position_ff <= group_position_in;
         held_sextets_ff   <= held_sextets_in;
         pad_count_ff      <= pad_count_in;
         error_code_ff     <= error_code_in;
      end
   end

endmodule

// File: design/b64d_queue.sv
// Short group queue between front end and byte serializer.
// Depends on b64d_pkg.
module b64d_queue import b64d_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      queue_ready,
   input  logic      pop,
   output logic      pop_valid,
   output entry_type pop_entry
);

   entry_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_pop;

   assign queue_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid   = (count_ff != '0);
   assign pop_entry   = mem_ff[rd_ptr_ff];
   assign do_pop      = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: design/b64d_back.sv
// Back end: takes one group from the queue and sends its bytes one beat each.
// Depends on b64d_pkg.
module b64d_back import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   input  entry_type  pop_entry,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last_result,
   output logic [1:0] rsp_status
);

   entry_type  cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       at_end;
   logic       beat_done;

   assign at_end          = (idx_ff == cur_ff.count - 2'd1);
   assign beat_done       = valid_ff & rsp_ready;
   assign pop             = pop_valid & (!valid_ff | (beat_done & at_end));

   assign rsp_valid       = valid_ff;
   assign rsp_data_byte   = cur_ff.data[idx_ff];
   assign rsp_last_result = cur_ff.last & at_end;
   assign rsp_status      = cur_ff.status;

   always_comb begin
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (pop) begin
         cur_in   = pop_entry;
         idx_in   = 2'd0;
         valid_in = 1'b1;
      end else if (beat_done) begin
         if (at_end) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// File: design/base64_stream_decoder.sv
// Base64 stream decoder: one character beat in per cycle while the queue has room,
// up to 3 byte beats out. A group goes through the queue, then the output register.
// Throughput: 1 character per cycle, 1 result beat per cycle (3 bytes per 4 chars)
// while rsp_ready is high; the serializer port sets the rate; queue is 4 groups.
// Reset is synchronous, active high: clears group state, queue and output stage,
// and sets the alphabet back to standard.
module base64_stream_decoder import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   // character beats
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_symbol,
   input  logic       req_final_symbol,
   // byte beats
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last_result,
   output logic [1:0] rsp_status
);

   // alphabet register: 0 standard (+ /), 1 URL-safe (- _)
   logic alphabet_select_ff, alphabet_select_in;

   // front -> queue
   logic      push;
   entry_type push_entry;
   logic      queue_ready;

   // queue -> back
   logic      pop;
   logic      pop_valid;
   entry_type pop_entry;

   assign alphabet_select_in = csr_write_enable ? csr_write_data : alphabet_select_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_select_ff <= 1'b0;
      end else begin
         alphabet_select_ff <= alphabet_select_in;
      end
   end

   // Front end classifies every character in its accept cycle and pushes a
   // group record whenever bytes come out or the text ends. Characters that
   // emit nothing (first three of a group, anything after an error) only
   // update state. Ready depends on queue space alone.
   b64d_front u_front (
      .clock            (clock),
      .reset            (reset),
      .alphabet_select  (alphabet_select_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_symbol       (req_symbol),
      .req_final_symbol (req_final_symbol),
      .queue_ready      (queue_ready),
      .push             (push),
      .push_entry       (push_entry)
   );

   // Decouples front from back so a stalled result side does not stop
   // character intake until the queue fills.
   b64d_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_entry  (push_entry),
      .queue_ready (queue_ready),
      .pop         (pop),
      .pop_valid   (pop_valid),
      .pop_entry   (pop_entry)
   );

   // Back end holds one group in its output register and walks its bytes;
   // the next group loads on the same edge the last byte is taken.
   b64d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_entry       (pop_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_last_result (rsp_last_result),
      .rsp_status      (rsp_status)
   );

endmodule

// File: design/base64_stream_decoder_checker.sv
// Port-level checks for the base64 stream decoder, bound to the top level.
// Depends on base64_stream_decoder_macros.svh and b64d_pkg.
`include "base64_stream_decoder_macros.svh"

module base64_stream_decoder_checker import b64d_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_last_result,
   input logic [1:0] rsp_status
);

   logic        rsp_stall;
   logic [10:0] rsp_payload;
   logic        err_beat;
   logic        err_shape;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_data_byte, rsp_last_result, rsp_status};
   assign err_beat    = rsp_valid && rsp_status != STATUS_OK;
   assign err_shape   = rsp_data_byte == 8'd0 && rsp_last_result &&
                        (rsp_status == STATUS_SYMBOL || rsp_status == STATUS_LENGTH);

   // stalled beat keeps its payload
   `B64D_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled beat changed")

   // an error beat is the single, closing beat of its text
   `B64D_ASSERT_IMPLY(a_err_beat, err_beat, err_shape, "malformed error beat")

   // reset empties the queue and the output stage
   `B64D_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, req_ready && !rsp_valid, "state left after reset")

endmodule

bind base64_stream_decoder base64_stream_decoder_checker u_checker (.*);
